// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic step;
        logic remove;
    } t_cell_ctl;

endpackage

// ----- rtl/core/spq_ifs.sv -----
interface spq_req_if #(
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] entry_handle;

    modport source (output valid, operation, key, entry_handle, input ready);
    modport sink   (input valid, operation, key, entry_handle, output ready);
endinterface

interface spq_rsp_if #(
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 8,
    parameter int OCC_BITS    = 7
);
    logic                   valid;
    logic                   ready;
    logic                   out_valid;
    logic [KEY_BITS-1:0]    out_key;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [1:0]             status;
    logic [OCC_BITS-1:0]    occupancy;

    modport source (output valid, out_valid, out_key, out_handle, status, occupancy,
                    input ready);
    modport sink   (input valid, out_valid, out_key, out_handle, status, occupancy,
                    output ready);
endinterface

// ----- rtl/core/spq_cell.sv -----
module spq_cell #(
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 8
) (
    input  logic                   i_clk,
    input  spq_pkg::t_cell_ctl     i_ctl,
    input  logic [KEY_BITS-1:0]    i_new_key,
    input  logic [HANDLE_BITS-1:0] i_new_handle,
    input  logic                   i_occ,
    input  logic                   i_tail,
    input  logic                   i_left_gt,
    input  logic [KEY_BITS-1:0]    i_left_key,
    input  logic [HANDLE_BITS-1:0] i_left_handle,
    input  logic [KEY_BITS-1:0]    i_right_key,
    input  logic [HANDLE_BITS-1:0] i_right_handle,
    output logic                   o_gt,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [HANDLE_BITS-1:0] o_handle
);

    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [KEY_BITS-1:0]    n_key;
    logic [HANDLE_BITS-1:0] n_handle;

    // stored entry leaves room for a smaller new key
    assign o_gt     = i_occ && (r_key > i_new_key);
    assign o_key    = r_key;
    assign o_handle = r_handle;

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.remove) begin
            n_key    = i_right_key;
            n_handle = i_right_handle;
        end else if (i_left_gt) begin
            n_key    = i_left_key;
            n_handle = i_left_handle;
        end else if (o_gt || i_tail) begin
            n_key    = i_new_key;
            n_handle = i_new_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_key    <= n_key;
            r_handle <= n_handle;
        end
    end

endmodule

// ----- rtl/core/stable_sorted_priority_queue_unit.sv -----
// stable sorted priority queue
// i_req carries requests: operation (insert or remove-minimum), key and
// entry_handle. o_rsp returns one response per request: out_valid, out_key
// and out_handle of the removed entry, a status code (ok, insert dropped
// because full, remove on empty queue) and the occupancy after the request.
// entries sit in a row of cells in ascending key order; an insert goes
// behind every entry with an equal or smaller key, so equal keys leave in
// arrival order. every cell compares against the broadcast key and takes
// its own, its neighbour's or the new entry.
// the response is registered and valid in the cycle after the request is accepted.
// throughput: one request per cycle while o_rsp takes each response.
// when o_rsp stalls, the response register holds and i_req.ready drops
// until it is taken.
// reset empties the queue and drops any pending response; no clearing
// pass is needed since only occupied cells are ever read.
module stable_sorted_priority_queue_unit #(
    parameter int CAPACITY    = 64,
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spq_req_if.sink          i_req,
    spq_rsp_if.source        o_rsp
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    n_count;
    logic                   r_rsp_valid;
    logic                   r_out_valid;
    logic [KEY_BITS-1:0]    r_out_key;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic [1:0]             r_status;
    logic [CNT_BITS-1:0]    r_occ;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   is_remove;
    logic [1:0]             status;
    spq_pkg::t_cell_ctl     ctl;

    logic [CAPACITY-1:0]    gt;
    logic [KEY_BITS-1:0]    cell_key    [CAPACITY];
    logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];

    assign full      = (r_count == CNT_BITS'(CAPACITY));
    assign empty     = (r_count == '0);
    assign is_remove = (i_req.operation == spq_pkg::OP_REMOVE);

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        ctl.remove = is_remove;
        ctl.step   = 1'b0;
        status     = spq_pkg::ST_OK;
        n_count    = r_count;
        if (is_remove) begin
            if (empty) begin
                status = spq_pkg::ST_EMPTY;
            end else begin
                ctl.step = accept;
                n_count  = r_count - CNT_BITS'(1);
            end
        end else begin
            if (full) begin
                status = spq_pkg::ST_FULL;
            end else begin
                ctl.step = accept;
                n_count  = r_count + CNT_BITS'(1);
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                   left_gt;
            logic [KEY_BITS-1:0]    left_key;
            logic [HANDLE_BITS-1:0] left_handle;
            logic [KEY_BITS-1:0]    right_key;
            logic [HANDLE_BITS-1:0] right_handle;

            if (gi == 0) begin : g_head
                assign left_gt     = 1'b0;
                assign left_key    = cell_key[gi];
                assign left_handle = cell_handle[gi];
            end else begin : g_body
                assign left_gt     = gt[gi-1];
                assign left_key    = cell_key[gi-1];
                assign left_handle = cell_handle[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_key    = cell_key[gi];
                assign right_handle = cell_handle[gi];
            end else begin : g_next
                assign right_key    = cell_key[gi+1];
                assign right_handle = cell_handle[gi+1];
            end

            spq_cell #(
                .KEY_BITS    (KEY_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (ctl),
                .i_new_key      (i_req.key),
                .i_new_handle   (i_req.entry_handle),
                .i_occ          (CNT_BITS'(gi) < r_count),
                .i_tail         (CNT_BITS'(gi) == r_count),
                .i_left_gt      (left_gt),
                .i_left_key     (left_key),
                .i_left_handle  (left_handle),
                .i_right_key    (right_key),
                .i_right_handle (right_handle),
                .o_gt           (gt[gi]),
                .o_key          (cell_key[gi]),
                .o_handle       (cell_handle[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (ctl.step) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_valid  <= ctl.step && is_remove;
            r_out_key    <= (is_remove && !empty) ? cell_key[0] : '0;
            r_out_handle <= (is_remove && !empty) ? cell_handle[0] : '0;
            r_status     <= status;
            r_occ        <= n_count;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.out_valid  = r_out_valid;
    assign o_rsp.out_key    = r_out_key;
    assign o_rsp.out_handle = r_out_handle;
    assign o_rsp.status     = r_status;
    assign o_rsp.occupancy  = r_occ;

endmodule
